FILE: sv/gf2m_pkg.sv
package gf2m_pkg;

    localparam int ElemW = 63;
    localparam int ModW  = 64;
    localparam int DegW  = 7;
    localparam int FieldDegreeMax = 63;

    typedef logic [ElemW-1:0] t_elem;
    typedef logic [ModW-1:0]  t_mod;

    typedef enum logic [2:0] {
        KIND_ADD = 3'd0,
        KIND_MUL = 3'd1,
        KIND_INV = 3'd2,
        KIND_DIV = 3'd3,
        KIND_POW = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_INV = 2'd1,
        ST_NO_INV   = 2'd2,
        ST_BAD_MOD  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_DEG, S_RED_A, S_RED_B, S_DISPATCH,
        S_INV_INIT, S_INV_DIV, S_INV_STEP, S_INV_FIN,
        S_MUL, S_POW_NEXT, S_DONE
    } t_state;

    // Degree of a 64-bit polynomial, -1 encoded as all ones (7'h7f).
    function automatic logic [DegW-1:0] poly_degree(input logic [ModW-1:0] v);
        logic [DegW-1:0] d;
        d = '1;
        for (int i = 0; i < ModW; i++) begin
            if (v[i]) begin
                d = DegW'(i);
            end
        end
        return d;
    endfunction

endpackage

FILE: sv/gf2m_mul.sv
// Bit-serial field multiplier: one bit of b per cycle, most significant first.
module gf2m_mul (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  gf2m_pkg::t_elem     i_a,
    input  gf2m_pkg::t_elem     i_b,
    input  gf2m_pkg::t_mod      i_mod,
    input  logic [6:0]          i_deg,
    output logic                o_done,
    output gf2m_pkg::t_elem     o_prod
);
    logic [63:0]     r_acc, n_acc;
    logic [6:0]      r_cnt, n_cnt;
    logic            r_busy, n_busy;
    logic            r_done, n_done;
    gf2m_pkg::t_elem r_a, r_b;
    logic [63:0]     sh;

    always_comb begin
        n_acc  = r_acc;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        sh     = {r_acc[62:0], 1'b0};
        if (i_start) begin
            n_acc  = '0;
            n_cnt  = i_deg;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (sh[i_deg[5:0]]) begin
                sh = sh ^ i_mod;
            end
            if (r_b[r_cnt[5:0] - 6'd1]) begin
                sh = sh ^ {1'b0, r_a};
            end
            n_acc = sh;
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_acc <= n_acc;
        r_cnt <= n_cnt;
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc[62:0];
endmodule

FILE: sv/gf2m_arithmetic_unit_top.sv
// Each operand is first reduced by the modulus, one reduction bit a cycle per operand;
// add then XORs the two and multiply runs one serial field multiply.
// Inverse and divide add one long-division step a cycle and a bit-serial carry-less product
// per Euclid quotient; power adds up to 126 serial multiplies.
// One item at a time, s_axis_tready high only while idle; a finished result
// waits in the output register. Reset: synchronous active-low, modulus returns to 283.
module gf2m_arithmetic_unit_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [63:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: operand_a [62:0], operand_b [125:63], exponent [189:126], zeros
    input  logic [191:0] s_axis_tdata,
    // tuser: kind [2:0]
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: result [62:0], zero
    output logic [63:0]  m_axis_tdata,
    // tuser: status [1:0]
    output logic [1:0]   m_axis_tuser
);
    gf2m_pkg::t_state r_state, n_state;
    logic [63:0]      r_mod;
    logic [2:0]       r_kind, n_kind;
    logic [63:0]      r_a, n_a;
    logic [63:0]      r_b, n_b;
    logic [63:0]      r_exp, n_exp;
    logic [6:0]       r_deg, n_deg;
    logic [5:0]       r_bit, n_bit;
    // Euclid registers
    logic [63:0]      r_ra, n_ra, r_rb, n_rb, r_r, n_r;
    logic [63:0]      r_q, n_q, r_prev, n_prev, r_cur, n_cur;
    logic [6:0]       r_i, n_i;
    // power
    logic [63:0]      r_res, n_res, r_base, n_base;
    logic             r_mphase, n_mphase;
    logic [1:0]       r_st, n_st;
    logic             r_ovalid, n_ovalid;
    logic [62:0]      r_oval, n_oval;
    logic [1:0]       r_ost, n_ost;

    logic             mul_start;
    gf2m_pkg::t_elem  mul_a, mul_b, mul_p;
    logic             mul_done;
    logic [6:0]       deg_rb, deg_r;

    gf2m_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .i_mod   (r_mod),
        .i_deg   (r_deg),
        .o_done  (mul_done),
        .o_prod  (mul_p)
    );

    assign deg_rb = gf2m_pkg::poly_degree(r_rb);
    assign deg_r  = gf2m_pkg::poly_degree(r_r);

    always_comb begin
        n_state = r_state; n_kind = r_kind; n_a = r_a; n_b = r_b; n_exp = r_exp;
        n_deg = r_deg; n_bit = r_bit; n_ra = r_ra; n_rb = r_rb; n_r = r_r;
        n_q = r_q; n_prev = r_prev; n_cur = r_cur; n_i = r_i; n_res = r_res;
        n_base = r_base; n_mphase = r_mphase; n_st = r_st;
        n_ovalid = r_ovalid; n_oval = r_oval; n_ost = r_ost;
        mul_start = 1'b0; mul_a = r_a[62:0]; mul_b = r_b[62:0];
        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            gf2m_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_kind  = s_axis_tuser;
                    n_a     = {1'b0, s_axis_tdata[62:0]};
                    n_b     = {1'b0, s_axis_tdata[125:63]};
                    n_exp   = s_axis_tdata[189:126];
                    n_st    = gf2m_pkg::ST_OK;
                    n_state = gf2m_pkg::S_DEG;
                end
            end
            gf2m_pkg::S_DEG: begin
                n_deg = gf2m_pkg::poly_degree(r_mod);
                n_bit = 6'd62;
                if (r_mod[63:1] == '0) begin
                    n_st = gf2m_pkg::ST_BAD_MOD;
                    n_res = '0;
                    n_state = gf2m_pkg::S_DONE;
                end else begin
                    n_state = gf2m_pkg::S_RED_A;
                end
            end
            gf2m_pkg::S_RED_A, gf2m_pkg::S_RED_B: begin
                // One bit of the reduction a cycle, from bit 62 down to the degree.
                if ({1'b0, r_bit} >= r_deg) begin
                    if (r_state == gf2m_pkg::S_RED_A) begin
                        if (r_a[r_bit]) n_a = r_a ^ (r_mod << (7'(r_bit) - r_deg));
                    end else begin
                        if (r_b[r_bit]) n_b = r_b ^ (r_mod << (7'(r_bit) - r_deg));
                    end
                end
                if ({1'b0, r_bit} <= r_deg || r_bit == 6'd0) begin
                    n_bit = 6'd62;
                    n_state = (r_state == gf2m_pkg::S_RED_A) ? gf2m_pkg::S_RED_B
                                                             : gf2m_pkg::S_DISPATCH;
                end else begin
                    n_bit = r_bit - 6'd1;
                end
            end
            gf2m_pkg::S_DISPATCH: begin
                case (r_kind)
                    gf2m_pkg::KIND_ADD: begin
                        n_res = r_a ^ r_b; n_state = gf2m_pkg::S_DONE;
                    end
                    gf2m_pkg::KIND_MUL: begin
                        mul_start = 1'b1; n_mphase = 1'b0;
                        n_state = gf2m_pkg::S_MUL;
                    end
                    gf2m_pkg::KIND_INV: begin
                        n_rb = r_a; n_state = gf2m_pkg::S_INV_INIT;
                    end
                    gf2m_pkg::KIND_DIV: begin
                        n_rb = r_b; n_state = gf2m_pkg::S_INV_INIT;
                    end
                    gf2m_pkg::KIND_POW: begin
                        if (r_exp == '0) begin
                            n_res = 64'd1; n_state = gf2m_pkg::S_DONE;
                        end else if (r_exp[63]) begin
                            n_exp = ~r_exp + 64'd1;
                            n_rb = r_a; n_state = gf2m_pkg::S_INV_INIT;
                        end else begin
                            n_base = r_a; n_res = 64'd1;
                            n_state = gf2m_pkg::S_POW_NEXT;
                        end
                    end
                    default: begin
                        n_res = '0; n_state = gf2m_pkg::S_DONE;
                    end
                endcase
            end
            gf2m_pkg::S_INV_INIT: begin
                n_ra = r_mod; n_prev = '0; n_cur = 64'd1;
                if (r_rb == '0) begin
                    n_st = gf2m_pkg::ST_ZERO_INV; n_state = gf2m_pkg::S_DONE;
                end else begin
                    n_r = r_mod; n_q = '0; n_state = gf2m_pkg::S_INV_DIV;
                end
            end
            gf2m_pkg::S_INV_DIV: begin
                // One long-division step a cycle.
                if (deg_r != 7'h7f && deg_r >= deg_rb) begin
                    n_q = r_q | (64'd1 << (deg_r - deg_rb));
                    n_r = r_r ^ (r_rb << (deg_r - deg_rb));
                end else begin
                    n_i = 7'd0; n_res = '0;
                    n_state = gf2m_pkg::S_INV_STEP;
                end
            end
            gf2m_pkg::S_INV_STEP: begin
                // Carry-less q*cur, one bit of q a cycle, accumulated in r_res.
                if (r_q[r_i[5:0]]) n_res = r_res ^ (r_cur << r_i[5:0]);
                if (r_i == 7'd63) begin
                    n_prev = r_cur;
                    n_cur = r_prev ^ n_res;
                    n_ra = r_rb;
                    n_rb = r_r;
                    if (r_r == '0) begin
                        n_state = gf2m_pkg::S_INV_FIN;
                    end else begin
                        n_r = r_rb; n_q = '0; n_state = gf2m_pkg::S_INV_DIV;
                    end
                end else begin
                    n_i = r_i + 7'd1;
                end
            end
            gf2m_pkg::S_INV_FIN: begin
                // The cofactor of a reduced element always stays below the field
                // degree, so it needs no further reduction.
                if (r_ra != 64'd1) begin
                    n_st = gf2m_pkg::ST_NO_INV; n_state = gf2m_pkg::S_DONE;
                end else begin
                    n_b = r_prev;
                    if (r_kind == gf2m_pkg::KIND_INV) begin
                        n_res = r_prev; n_state = gf2m_pkg::S_DONE;
                    end else if (r_kind == gf2m_pkg::KIND_DIV) begin
                        mul_b = r_prev[62:0]; mul_start = 1'b1; n_mphase = 1'b0;
                        n_state = gf2m_pkg::S_MUL;
                    end else begin
                        n_base = r_prev; n_res = 64'd1;
                        n_state = gf2m_pkg::S_POW_NEXT;
                    end
                end
            end
            gf2m_pkg::S_POW_NEXT: begin
                if (r_exp == '0) begin
                    n_state = gf2m_pkg::S_DONE;
                end else begin
                    mul_a = r_res[62:0]; mul_b = r_base[62:0];
                    mul_start = r_exp[0];
                    n_mphase = r_exp[0] ? 1'b0 : 1'b1;
                    if (!r_exp[0]) begin
                        mul_a = r_base[62:0]; mul_start = 1'b1;
                    end
                    n_state = gf2m_pkg::S_MUL;
                end
            end
            gf2m_pkg::S_MUL: begin
                if (mul_done) begin
                    if (r_kind != gf2m_pkg::KIND_POW) begin
                        n_res = {1'b0, mul_p}; n_state = gf2m_pkg::S_DONE;
                    end else if (!r_mphase) begin
                        n_res = {1'b0, mul_p}; n_mphase = 1'b1;
                        mul_a = r_base[62:0]; mul_b = r_base[62:0]; mul_start = 1'b1;
                    end else begin
                        n_base = {1'b0, mul_p}; n_exp = r_exp >> 1;
                        n_state = gf2m_pkg::S_POW_NEXT;
                    end
                end
            end
            gf2m_pkg::S_DONE: begin
                // The result moves to the output register once that register is free
                // or is being emptied by a transfer in this cycle.
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_oval = (r_st == gf2m_pkg::ST_OK) ? r_res[62:0] : '0;
                    n_ost = r_st;
                    n_state = gf2m_pkg::S_IDLE;
                end
            end
            default: n_state = gf2m_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= gf2m_pkg::S_IDLE;
            r_mod    <= 64'd283;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) r_mod <= i_cfg_wdata;
        end
        r_kind <= n_kind; r_a <= n_a; r_b <= n_b; r_exp <= n_exp; r_deg <= n_deg;
        r_bit <= n_bit; r_ra <= n_ra; r_rb <= n_rb; r_r <= n_r; r_q <= n_q;
        r_prev <= n_prev; r_cur <= n_cur; r_i <= n_i; r_res <= n_res;
        r_base <= n_base; r_mphase <= n_mphase; r_st <= n_st; r_oval <= n_oval;
        r_ost <= n_ost;
    end

    assign s_axis_tready = (r_state == gf2m_pkg::S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {1'b0, r_oval};
    assign m_axis_tuser  = r_ost;
endmodule

FILE: sv/gf2m_checker.sv
module gf2m_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("output changed while stalled");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != gf2m_pkg::ST_OK |-> m_axis_tdata == '0)
        else $error("nonzero result with error status");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("accepted twice in a row");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");
endmodule

bind gf2m_arithmetic_unit_top gf2m_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
);
